[src/cpi_pkg.sv]
// ----------------------------------------------------------------------------
// cpi_pkg
// Shared types for the Coons patch interpolator: term codes, config indices,
// FSM state, controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package cpi_pkg;

	localparam int WEIGHT_BITS = 17;
	localparam int WPROD_BITS  = 33;
	localparam int ROOT_BITS   = 13;
	localparam int RAD_BITS    = 26;
	localparam int REM_BITS    = 16;

	typedef enum logic [2:0] {
		TERM_B0_I  = 3'd0,
		TERM_B2_I  = 3'd1,
		TERM_B3_J  = 3'd2,
		TERM_B1_J  = 3'd3,
		TERM_C00   = 3'd4,
		TERM_C10   = 3'd5,
		TERM_C11   = 3'd6,
		TERM_C01   = 3'd7
	} term_t;

	typedef enum logic [1:0] {
		CFG_LAST_INDEX = 2'd0,
		CFG_STEP       = 2'd1,
		CFG_NORMALIZE  = 2'd2
	} cfg_idx_t;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_WGT  = 9'b000000010,
		S_CORN = 9'b000000100,
		S_RUN  = 9'b000001000,
		S_RND  = 9'b000010000,
		S_SQ   = 9'b000100000,
		S_ARG  = 9'b001000000,
		S_ROOT = 9'b010000000,
		S_DONE = 9'b100000000
	} state_t;

	typedef struct packed {
		logic  cap;
		logic  wgt;
		logic  corn;
		logic  rd_en;
		term_t term;
		logic  rnd;
		logic  sq;
		logic  arg;
		logic  root_step;
	} dp_cmd_t;

endpackage

[src/cpi_ram.sv]
// ----------------------------------------------------------------------------
// cpi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cpi_ram #(
	parameter int WIDTH = 120,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[src/cpi_ctrl.sv]
// ----------------------------------------------------------------------------
// cpi_ctrl
// Sequencer: weights, eight boundary reads, rounding, optional square root.
// ----------------------------------------------------------------------------
module cpi_ctrl
	import cpi_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    op,
	input  logic    normalize,
	output logic    busy,
	output logic    done,
	output dp_cmd_t cmd
);

	state_t     state_q;
	state_t     state_nx;
	logic [3:0] cnt_q;
	logic       query;

	assign query = start && op && (state_q == S_IDLE);
	assign busy  = (state_q != S_IDLE);
	assign done  = (state_q == S_DONE);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: if (query) state_nx = S_WGT;
			S_WGT:  state_nx = S_CORN;
			S_CORN: state_nx = S_RUN;
			S_RUN:  if (cnt_q == 4'd9) state_nx = S_RND;
			S_RND:  state_nx = normalize ? S_SQ : S_DONE;
			S_SQ:   state_nx = S_ARG;
			S_ARG:  state_nx = S_ROOT;
			S_ROOT: if (cnt_q == 4'(ROOT_BITS - 1)) state_nx = S_DONE;
			S_DONE: state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q != state_nx) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 4'd1;
			end
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.cap       = query;
		cmd.wgt       = (state_q == S_WGT);
		cmd.corn      = (state_q == S_CORN);
		cmd.rd_en     = (state_q == S_RUN) && !cnt_q[3];
		cmd.term      = term_t'(cnt_q[2:0]);
		cmd.rnd       = (state_q == S_RND);
		cmd.sq        = (state_q == S_SQ);
		cmd.arg       = (state_q == S_ARG);
		cmd.root_step = (state_q == S_ROOT);
	end

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held longer than one cycle");
	a_rd_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> (state_q == S_RUN)) else $error("read outside run phase");
	a_query_start: assert property (@(posedge clk) disable iff (!arst_n)
		query |=> (state_q == S_WGT)) else $error("query not started");
	a_no_root_off: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RND) && !normalize |=> done) else $error("root run when off");

endmodule

[src/cpi_dp.sv]
// ----------------------------------------------------------------------------
// cpi_dp
// Datapath: boundary store, weight products, accumulators, rounding, sqrt.
// ----------------------------------------------------------------------------
module cpi_dp
	import cpi_pkg::*;
#(
	parameter int MAX_SIDE_SAMPLES = 64,
	parameter int COORD_BITS       = 20
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dp_cmd_t                      cmd,
	input  logic                         wr_en,
	input  logic [1:0]                   wr_side,
	input  logic [5:0]                   wr_idx,
	input  logic [6*COORD_BITS-1:0]      wr_data,
	input  logic [5:0]                   q_i,
	input  logic [5:0]                   q_j,
	input  logic [5:0]                   last_index,
	input  logic [15:0]                  step_fraction,
	input  logic                         normalize,
	output logic signed [COORD_BITS-1:0] res [6],
	output logic                         root_clamped
);

	localparam int CW    = COORD_BITS;
	localparam int DEPTH = 4 * MAX_SIDE_SAMPLES;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = CW + WPROD_BITS + 1;
	localparam int ACCW  = PW + 4;
	localparam int SQW   = 2 * CW;
	localparam int ARGW  = SQW + 2;
	localparam logic [WEIGHT_BITS-1:0] ONE = WEIGHT_BITS'(65536);

	function automatic logic [AW-1:0] addr_of(input logic [1:0] sd, input logic [5:0] ix);
		addr_of = AW'(int'(sd) * MAX_SIDE_SAMPLES + int'(ix));
	endfunction

	function automatic logic in_range(input logic [5:0] ix);
		in_range = (int'(ix) < MAX_SIDE_SAMPLES);
	endfunction

	logic [5:0] i_q, j_q, l_q;
	logic [WEIGHT_BITS-1:0] t_q, s_q, u_q, v_q;
	logic [WPROD_BITS-1:0]  vu_q, vt_q, st_q, su_q;
	logic [21:0] ti, sj;

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			i_q <= q_i;
			j_q <= q_j;
			l_q <= last_index;
		end
		if (cmd.wgt) begin
			t_q <= (ti > 22'(ONE)) ? ONE : WEIGHT_BITS'(ti);
			s_q <= (sj > 22'(ONE)) ? ONE : WEIGHT_BITS'(sj);
		end
		if (cmd.corn) begin
			vu_q <= WPROD_BITS'(34'(v_q) * 34'(u_q));
			vt_q <= WPROD_BITS'(34'(v_q) * 34'(t_q));
			st_q <= WPROD_BITS'(34'(s_q) * 34'(t_q));
			su_q <= WPROD_BITS'(34'(s_q) * 34'(u_q));
		end
	end

	assign ti  = i_q * step_fraction;
	assign sj  = j_q * step_fraction;
	assign u_q = ONE - t_q;
	assign v_q = ONE - s_q;

	logic [1:0]    rd_side;
	logic [5:0]    rd_idx;
	logic [6*CW-1:0] rdata;
	logic [AW-1:0] waddr;

	always_comb begin
		case (cmd.term)
			TERM_B0_I: begin rd_side = 2'd0; rd_idx = i_q;  end
			TERM_B2_I: begin rd_side = 2'd2; rd_idx = i_q;  end
			TERM_B3_J: begin rd_side = 2'd3; rd_idx = j_q;  end
			TERM_B1_J: begin rd_side = 2'd1; rd_idx = j_q;  end
			TERM_C00:  begin rd_side = 2'd0; rd_idx = 6'd0; end
			TERM_C10:  begin rd_side = 2'd0; rd_idx = l_q;  end
			TERM_C11:  begin rd_side = 2'd2; rd_idx = l_q;  end
			TERM_C01:  begin rd_side = 2'd2; rd_idx = 6'd0; end
			default:   begin rd_side = 2'd0; rd_idx = 6'd0; end
		endcase
	end

	assign waddr = addr_of(wr_side, wr_idx);

	cpi_ram #(.WIDTH(6 * CW), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (wr_en && in_range(wr_idx)),
		.waddr (waddr),
		.wdata (wr_data),
		.re    (cmd.rd_en),
		.raddr (addr_of(rd_side, rd_idx)),
		.rdata (rdata)
	);

	logic  vld_s1, zero_s1, vld_s2, neg_s2;
	term_t term_s1;
	logic [WPROD_BITS-1:0] w_s1;
	logic signed [PW-1:0]   prod_s2 [6];
	logic signed [ACCW-1:0] acc_q [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.rd_en;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		term_s1 <= cmd.term;
		zero_s1 <= !in_range(rd_idx);
	end

	always_comb begin
		case (term_s1)
			TERM_B0_I: w_s1 = {v_q, 16'd0};
			TERM_B2_I: w_s1 = {s_q, 16'd0};
			TERM_B3_J: w_s1 = {u_q, 16'd0};
			TERM_B1_J: w_s1 = {t_q, 16'd0};
			TERM_C00:  w_s1 = vu_q;
			TERM_C10:  w_s1 = vt_q;
			TERM_C11:  w_s1 = st_q;
			TERM_C01:  w_s1 = su_q;
			default:   w_s1 = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		neg_s2 <= term_s1[2];
		for (int c = 0; c < 6; c++) begin
			prod_s2[c] <= zero_s1 ? '0 :
				PW'($signed(rdata[c*CW +: CW])) * $signed(PW'({1'b0, w_s1}));
		end
		for (int c = 0; c < 6; c++) begin
			if (cmd.wgt) begin
				acc_q[c] <= '0;
			end else if (vld_s2) begin
				acc_q[c] <= neg_s2 ? acc_q[c] - ACCW'(prod_s2[c])
				                   : acc_q[c] + ACCW'(prod_s2[c]);
			end
		end
	end

	logic signed [ACCW-1:0] rsum [6];
	logic signed [ACCW-33:0] rsh [6];
	logic signed [CW-1:0]   res_q [6];

	always_comb begin
		for (int c = 0; c < 6; c++) begin
			rsum[c] = acc_q[c] + (ACCW'(1) <<< 31);
			rsh[c]  = rsum[c][ACCW-1:32];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rnd) begin
			for (int c = 0; c < 6; c++) begin
				if (rsh[c] > (ACCW-32)'((1 <<< (CW - 1)) - 1)) begin
					res_q[c] <= {1'b0, {(CW-1){1'b1}}};
				end else if (rsh[c] < -(ACCW-32)'(1 <<< (CW - 1))) begin
					res_q[c] <= {1'b1, {(CW-1){1'b0}}};
				end else begin
					res_q[c] <= CW'(rsh[c]);
				end
			end
		end
	end

	logic signed [SQW-1:0]  xsq_q, ysq_q;
	logic signed [ARGW-1:0] arg;
	logic                   neg_q;
	logic [RAD_BITS-1:0]    rad_q;
	logic [REM_BITS-1:0]    rem_q;
	logic [ROOT_BITS-1:0]   root_q;
	logic [REM_BITS+1:0]    rem_nx;
	logic [REM_BITS+1:0]    trial;

	assign arg    = (ARGW'(1) <<< 24) - ARGW'(xsq_q) - ARGW'(ysq_q);
	assign rem_nx = {rem_q, rad_q[RAD_BITS-1 -: 2]};
	assign trial  = (REM_BITS+2)'({root_q, 2'b01});

	always_ff @(posedge clk) begin
		if (cmd.sq) begin
			xsq_q <= res_q[3] * res_q[3];
			ysq_q <= res_q[4] * res_q[4];
		end
		if (cmd.arg) begin
			neg_q  <= arg[ARGW-1];
			rad_q  <= arg[ARGW-1] ? '0 : RAD_BITS'(arg);
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.root_step) begin
			rad_q <= rad_q << 2;
			if (rem_nx >= trial) begin
				rem_q  <= REM_BITS'(rem_nx - trial);
				root_q <= {root_q[ROOT_BITS-2:0], 1'b1};
			end else begin
				rem_q  <= REM_BITS'(rem_nx);
				root_q <= {root_q[ROOT_BITS-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 5; c++) begin
			res[c] = res_q[c];
		end
		if (!normalize) begin
			res[5] = res_q[5];
		end else if (neg_q) begin
			res[5] = '0;
		end else begin
			res[5] = CW'({1'b0, root_q});
		end
	end

	assign root_clamped = normalize && neg_q;

endmodule

[src/coons_patch_interpolator_top.sv]
// ----------------------------------------------------------------------------
// coons_patch_interpolator_top
// Bilinearly blended Coons patch over four stored boundary curves.
// ----------------------------------------------------------------------------
// A load (op=0) is written to the boundary store in the accept cycle and
// gives no result; the next item may start in the following cycle. A query
// (op=1) holds busy from the accept edge until done, which is high in the
// last busy cycle. Its steps: a weight step, a corner-product step, eight
// store reads through the single RAM read port, drained through the
// product and accumulator registers, rounding, and with normalize_z a
// squaring step, an argument step and a bit-serial 13-bit square root.
// The next item is accepted in the cycle after done. The result
// is on the out ports for the one cycle that done is high; the receiver
// cannot stall.
// ----------------------------------------------------------------------------
module coons_patch_interpolator_top
	import cpi_pkg::*;
#(
	parameter int MAX_SIDE_SAMPLES = 64,
	parameter int COORD_BITS       = 20
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	output logic                         done,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [15:0]                  cfg_data,
	input  logic                         op,
	input  logic [1:0]                   side,
	input  logic [5:0]                   first_index,
	input  logic [5:0]                   second_index,
	input  logic signed [COORD_BITS-1:0] pos_x,
	input  logic signed [COORD_BITS-1:0] pos_y,
	input  logic signed [COORD_BITS-1:0] pos_z,
	input  logic signed [COORD_BITS-1:0] norm_x,
	input  logic signed [COORD_BITS-1:0] norm_y,
	input  logic signed [COORD_BITS-1:0] norm_z,
	output logic signed [COORD_BITS-1:0] out_pos_x,
	output logic signed [COORD_BITS-1:0] out_pos_y,
	output logic signed [COORD_BITS-1:0] out_pos_z,
	output logic signed [COORD_BITS-1:0] out_norm_x,
	output logic signed [COORD_BITS-1:0] out_norm_y,
	output logic signed [COORD_BITS-1:0] out_norm_z,
	output logic                         root_clamped
);

	logic [5:0]  last_index_q;
	logic [15:0] step_q;
	logic        normalize_q;
	dp_cmd_t     cmd;
	logic signed [COORD_BITS-1:0] res [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_index_q <= 6'd9;
			step_q       <= 16'd7282;
			normalize_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_LAST_INDEX: last_index_q <= cfg_data[5:0];
				CFG_STEP:       step_q       <= cfg_data;
				CFG_NORMALIZE:  normalize_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	cpi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.op        (op),
		.normalize (normalize_q),
		.busy      (busy),
		.done      (done),
		.cmd       (cmd)
	);

	cpi_dp #(
		.MAX_SIDE_SAMPLES (MAX_SIDE_SAMPLES),
		.COORD_BITS       (COORD_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.wr_en         (start && !busy && !op),
		.wr_side       (side),
		.wr_idx        (first_index),
		.wr_data       ({norm_z, norm_y, norm_x, pos_z, pos_y, pos_x}),
		.q_i           (first_index),
		.q_j           (second_index),
		.last_index    (last_index_q),
		.step_fraction (step_q),
		.normalize     (normalize_q),
		.res           (res),
		.root_clamped  (root_clamped)
	);

	assign out_pos_x  = res[0];
	assign out_pos_y  = res[1];
	assign out_pos_z  = res[2];
	assign out_norm_x = res[3];
	assign out_norm_y = res[4];
	assign out_norm_z = res[5];

endmodule
